>>> hdl/mftab_pkg.sv
// Shared types and constants for the multicast filter mode table.
// No dependencies; compiled first.
package mftab_pkg;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_SET   = 2'd1,
    OP_TICK  = 2'd2
  } mftab_op_t;

  localparam int unsigned TICKS_PER_TENTH = 100;
  localparam int unsigned COUNT_W         = 23;
  localparam logic [15:0] GMI_RESET       = 16'd2600;
  localparam logic [2:0]  ADDR_GMI_TENTHS = 3'd0;

  // One stored table entry; a cleared word is a free slot.
  typedef struct packed {
    logic               valid;
    logic               timer_on;
    logic [3:0]         iface;
    logic [31:0]        group;
    logic [COUNT_W-1:0] countdown;
  } mftab_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a new item, clear scan results
    logic rd_en;   // read entry at addr
    logic clear;   // write a free entry at addr
    logic commit;  // final write for a set, load result payload
  } mftab_cmd_t;

endpackage

>>> hdl/mftab_if.sv
// Valid/ready channel interfaces for item and result beats.
// No dependencies.
interface mftab_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  iface;
  logic [31:0] group_addr;
  logic        want_include;

  modport source (output valid, operation, iface, group_addr, want_include, input ready);
  modport sink   (input valid, operation, iface, group_addr, want_include, output ready);
endinterface

interface mftab_out_if;
  logic valid;
  logic ready;
  logic include_mode;
  logic status;

  modport source (output valid, include_mode, status, input ready);
  modport sink   (input valid, include_mode, status, output ready);
endinterface

>>> hdl/multicast_filter_mode_table_core.sv
// Top level of the multicast filter mode table: APB register, controller, datapath.
// Depends on mftab_pkg, mftab_if, mftab_ctrl, mftab_dp, mftab_ram.
//
//   channel  dir   handshake          beat
//   item     in    valid/ready        operation, iface, group_addr, want_include
//   result   out   valid/ready        include_mode, status
//   apb      in    psel/penable       gmi_tenths at byte address 0
//
// Every item scans the whole table: one entry is read
// from the single-read-port table RAM per cycle, all entries for every operation.
// After reset a sweep frees all entries; item ready stays low.
// The result sits in an output register; the next item is taken and scanned
// while it waits, and that item's finish stalls until the result slot frees.
module multicast_filter_mode_table_core #(
  parameter int ENTRIES    = 64,
  parameter int INTERFACES = 16
) (
  input  logic        clk,
  input  logic        rst,
  mftab_in_if.sink    item,
  mftab_out_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mftab_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0]   gmi_tenths;
  mftab_cmd_t    cmd;
  logic [AW-1:0] addr;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_GMI_TENTHS) ? {16'd0, gmi_tenths} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gmi_tenths <= GMI_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_GMI_TENTHS)) begin
      gmi_tenths <= pwdata[15:0];
    end
  end

  mftab_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd),
    .addr      (addr)
  );

  mftab_dp #(
    .ENTRIES    (ENTRIES),
    .INTERFACES (INTERFACES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .addr         (addr),
    .gmi_tenths   (gmi_tenths),
    .operation    (item.operation),
    .iface        (item.iface),
    .group_addr   (item.group_addr),
    .want_include (item.want_include),
    .include_mode (result.include_mode),
    .status       (result.status)
  );

endmodule

>>> hdl/mftab_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mftab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mftab_ctrl.sv
// Controller: clearing sweep, entry scan sequencing, result beat valid.
// Depends on mftab_pkg.
module mftab_ctrl #(
  parameter int ENTRIES = 64
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output mftab_pkg::mftab_cmd_t                     cmd,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr
);
  import mftab_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1) + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          out_free;

  assign out_free = !out_valid || out_ready;
  assign addr     = cnt[AW-1:0];
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      ST_CLEAR:  cmd.clear  = 1'b1;
      ST_IDLE:   cmd.load   = in_valid;
      ST_SCAN:   cmd.rd_en  = (cnt < CW'(ENTRIES));
      ST_FINISH: cmd.commit = out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // last read result is checked in the cycle cnt reaches ENTRIES
          cnt <= cnt + CW'(1);
          if (cnt == CW'(ENTRIES)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/mftab_dp.sv
// Datapath: item registers, entry RAM, match and free-slot search,
// tick write-back, result payload. Depends on mftab_pkg, mftab_ram.
module mftab_dp #(
  parameter int ENTRIES    = 64,
  parameter int INTERFACES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  mftab_pkg::mftab_cmd_t                     cmd,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] addr,
  input  logic [15:0]                               gmi_tenths,
  input  logic [1:0]                                operation,
  input  logic [3:0]                                iface,
  input  logic [31:0]                               group_addr,
  input  logic                                      want_include,
  output logic                                      include_mode,
  output logic                                      status
);
  import mftab_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [1:0]         op;
  logic [3:0]         ifc;
  logic [31:0]        grp;
  logic               incl;
  logic               set_ok;
  logic               is_tick;
  logic [COUNT_W-1:0] gmi_ticks;

  logic               chk;
  logic [AW-1:0]      chk_addr;
  logic               match_found;
  logic               free_found;
  logic [AW-1:0]      match_idx;
  logic [AW-1:0]      free_idx;

  logic               we;
  logic [AW-1:0]      waddr;
  mftab_entry_t       wdata;
  mftab_entry_t       rd_entry;
  mftab_entry_t       new_entry;
  logic               hit;

  assign is_tick = (op == OP_TICK);
  assign hit     = rd_entry.valid && (rd_entry.iface == ifc) && (rd_entry.group == grp);

  mftab_ram #(
    .WIDTH ($bits(mftab_entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (rd_entry)
  );

  always_comb begin
    new_entry.valid     = 1'b1;
    new_entry.timer_on  = (ifc != 4'd0);
    new_entry.iface     = ifc;
    new_entry.group     = grp;
    new_entry.countdown = (ifc != 4'd0) ? gmi_ticks : '0;
  end

  always_comb begin
    we    = 1'b0;
    waddr = chk_addr;
    wdata = '0;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = addr;
    end else if (chk && is_tick && rd_entry.valid && rd_entry.timer_on) begin
      we = 1'b1;
      // countdown of one or less expires: entry freed
      if (rd_entry.countdown > COUNT_W'(1)) begin
        wdata           = rd_entry;
        wdata.countdown = rd_entry.countdown - COUNT_W'(1);
      end
    end else if (cmd.commit && set_ok) begin
      waddr = match_found ? match_idx : free_idx;
      if (incl) begin
        we = match_found;
      end else if (match_found) begin
        // refresh on the local interface leaves the entry as it is
        we    = (ifc != 4'd0);
        wdata = new_entry;
      end else begin
        we    = free_found;
        wdata = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk         <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      chk <= cmd.rd_en;
      if (cmd.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (chk && !is_tick) begin
        if (hit) begin
          match_found <= 1'b1;
        end
        if (!rd_entry.valid) begin
          free_found <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_addr  <= addr;
    gmi_ticks <= COUNT_W'(32'(gmi_tenths) * TICKS_PER_TENTH);
    if (cmd.load) begin
      op     <= operation;
      ifc    <= iface;
      grp    <= group_addr;
      incl   <= want_include;
      set_ok <= (operation == OP_SET) && (32'(iface) < INTERFACES);
    end
    if (chk && hit && !match_found) begin
      match_idx <= chk_addr;
    end
    if (chk && !rd_entry.valid && !free_found) begin
      free_idx <= chk_addr;
    end
    if (cmd.commit) begin
      if (is_tick) begin
        include_mode <= 1'b1;
        status       <= 1'b0;
      end else if (set_ok) begin
        if (incl) begin
          include_mode <= 1'b1;
          status       <= 1'b0;
        end else if (match_found || free_found) begin
          include_mode <= 1'b0;
          status       <= 1'b0;
        end else begin
          include_mode <= 1'b1;
          status       <= 1'b1;
        end
      end else begin
        include_mode <= !match_found;
        status       <= 1'b0;
      end
    end
  end

endmodule
